// ===== design/ipv6tp_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv6tp_pkg
// Shared types and constants of the IPv6 text address parser.
// ----------------------------------------------------------------------------
package ipv6tp_pkg;

  // address geometry
  localparam int unsigned NUM_GROUPS = 8;
  localparam int unsigned GROUP_W    = 16;
  localparam int unsigned HALF_W     = 64;

  // group count holds 0..8, digit count holds 0..4
  localparam logic [3:0] GROUPS_FULL = 4'd8;
  localparam logic [2:0] MAX_DIGITS  = 3'd4;

  // character codes
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_F     = 8'h66;
  localparam logic [3:0] TEN        = 4'd10;

  // one parsed address, as handed from the front part to the back part
  typedef struct packed {
    logic [NUM_GROUPS-1:0][GROUP_W-1:0] words;
    logic [3:0]                         count;
    logic [3:0]                         gap;
    logic                               err;
  } addr_rec_t;

  // queue handshake toward the back part
  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctl_t;

endpackage

// ===== design/ipv6tp_front.sv =====
// ----------------------------------------------------------------------------
// ipv6tp_front
// Character front end: builds group words, tracks the compression point and
// errors, and pushes one address record on the final character.
// ----------------------------------------------------------------------------
module ipv6tp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] char_code
  input  logic                  in_tlast,   // last_char
  input  logic                  q_full,
  output logic                  q_push,
  output ipv6tp_pkg::addr_rec_t q_rec
);
  import ipv6tp_pkg::*;

  logic [NUM_GROUPS-1:0][GROUP_W-1:0] words_r, words_nxt;
  logic [GROUP_W-1:0] fval_r, fval_nxt, fval_step;
  logic [2:0]         dig_r, dig_nxt, dig_step;
  logic [3:0]         cnt_r, cnt_nxt, cnt_close;
  logic [3:0]         gap_r, gap_nxt, gap_close;
  logic               err_r, err_nxt, err_step, err_close;
  logic               accept, is_colon, is_dec, is_hex, bad;
  logic [3:0]         digit;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // digit decode, non-hex reads as zero
  always_comb begin
    is_colon = (in_tdata == CHAR_COLON);
    is_dec   = (in_tdata >= CHAR_ZERO) && (in_tdata <= CHAR_NINE);
    is_hex   = (in_tdata >= CHAR_A) && (in_tdata <= CHAR_F);
    bad      = !is_dec && !is_hex;
    if (is_dec) begin
      digit = 4'(in_tdata - CHAR_ZERO);
    end else if (is_hex) begin
      digit = 4'(in_tdata - CHAR_A) + TEN;
    end else begin
      digit = 4'd0;
    end
  end

  // digit shift into the open field
  always_comb begin
    fval_step = fval_r;
    dig_step  = dig_r;
    err_step  = err_r;
    if (!is_colon) begin
      fval_step = {fval_r[GROUP_W-5:0], digit};
      if (dig_r >= MAX_DIGITS) begin
        err_step = 1'b1;
      end else begin
        dig_step = dig_r + 3'd1;
      end
      if (bad) begin
        err_step = 1'b1;
      end
    end
  end

  // field close and end of address
  always_comb begin
    words_nxt = words_r;
    cnt_close = cnt_r;
    gap_close = gap_r;
    err_close = err_step;
    fval_nxt  = fval_step;
    dig_nxt   = dig_step;
    if (is_colon || in_tlast) begin
      if (dig_step == 3'd0) begin
        gap_close = cnt_r;
      end else if (cnt_r < GROUPS_FULL) begin
        words_nxt[cnt_r[2:0]] = fval_step;
        cnt_close = cnt_r + 4'd1;
      end else begin
        err_close = 1'b1;
      end
      fval_nxt = '0;
      dig_nxt  = '0;
    end
    cnt_nxt = cnt_close;
    gap_nxt = gap_close;
    err_nxt = err_close;
    if (in_tlast) begin
      cnt_nxt = '0;
      gap_nxt = '0;
      err_nxt = 1'b0;
    end
  end

  assign q_push      = accept && in_tlast;
  assign q_rec.words = words_nxt;
  assign q_rec.count = cnt_close;
  assign q_rec.gap   = gap_close;
  assign q_rec.err   = err_close;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fval_r <= '0;
      dig_r  <= '0;
      cnt_r  <= '0;
      gap_r  <= '0;
      err_r  <= 1'b0;
    end else if (accept) begin
      fval_r <= fval_nxt;
      dig_r  <= dig_nxt;
      cnt_r  <= cnt_nxt;
      gap_r  <= gap_nxt;
      err_r  <= err_nxt;
    end
  end

  // group words, only entries below the count are ever read
  always_ff @(posedge clk) begin
    if (accept) begin
      words_r <= words_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= GROUPS_FULL)
    else $error("group count past eight");
  a_gap_range: assert property (@(posedge clk) disable iff (!rst_n)
    gap_r <= cnt_r)
    else $error("compression point beyond group count");
  a_dig_range: assert property (@(posedge clk) disable iff (!rst_n)
    dig_r <= MAX_DIGITS)
    else $error("digit count past four");

endmodule

// ===== design/ipv6tp_queue.sv =====
// ----------------------------------------------------------------------------
// ipv6tp_queue
// Two-entry queue of parsed address records between front and back.
// ----------------------------------------------------------------------------
module ipv6tp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ipv6tp_pkg::addr_rec_t push_rec,
  output logic                  full,
  output ipv6tp_pkg::q_ctl_t    ctl_out,
  input  logic                  pop_in,
  output ipv6tp_pkg::addr_rec_t pop_rec
);
  import ipv6tp_pkg::*;

  addr_rec_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign full          = (cnt_r == 2'd2);
  assign ctl_out.valid = (cnt_r != 2'd0);
  assign do_pop        = pop_in && ctl_out.valid;
  assign ctl_out.pop   = do_pop;
  assign pop_rec       = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, do_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("queue fill count out of range");
  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("request pushed into full queue");

endmodule

// ===== design/ipv6tp_back.sv =====
// ----------------------------------------------------------------------------
// ipv6tp_back
// Back end: expands the compression gap, right-aligns trailing groups and
// holds the finished address in the output register.
// ----------------------------------------------------------------------------
module ipv6tp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipv6tp_pkg::q_ctl_t    q_ctl,
  input  ipv6tp_pkg::addr_rec_t q_rec,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [127:0]          out_tdata,  // [63:0] addr_high, [127:64] addr_low
  output logic                  out_tuser   // malformed
);
  import ipv6tp_pkg::*;

  logic [NUM_GROUPS-1:0][GROUP_W-1:0] addr;
  logic [HALF_W-1:0] high_r, low_r;
  logic              err_r, valid_r, load;
  logic [3:0]        start;
  logic [3:0]        pos;

  // groups below the gap stay, trailing groups move to the end, gap is zero
  always_comb begin
    start = GROUPS_FULL - (q_rec.count - q_rec.gap);
    for (int i = 0; i < NUM_GROUPS; i++) begin
      pos = 4'(i);
      if (pos < q_rec.gap) begin
        addr[i] = q_rec.words[i];
      end else if (pos < start) begin
        addr[i] = '0;
      end else begin
        addr[i] = q_rec.words[3'(pos + q_rec.count)];
      end
    end
  end

  assign load  = q_ctl.valid && (!valid_r || out_tready);
  assign q_pop = load;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      high_r <= {addr[0], addr[1], addr[2], addr[3]};
      low_r  <= {addr[4], addr[5], addr[6], addr[7]};
      err_r  <= q_rec.err;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {low_r, high_r};
  assign out_tuser  = err_r;

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctl.pop |=> out_tvalid)
    else $error("popped request not presented");
  a_pop_matches: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctl.pop == load)
    else $error("queue pop out of step with output load");

endmodule

// ===== design/ipv6_text_address_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_unit
// Parses IPv6 address text, one character per request, into a 128-bit address.
//
//   channel  dir  payload                               marker
//   in_      in   tdata[7:0] char_code                  tlast = last_char
//   out_     out  tdata[63:0] addr_high, [127:64] low   tuser = malformed
//
// One character is accepted per cycle while in_tready is high; the final character's
// record is registered in the queue, then gap-expanded into the output register.
// The two-entry record queue lets the front keep parsing while results wait.
// in_tready drops only when that queue is full behind a stalled output.
// Reset (rst_n low, synchronous) clears the field, count and queue state.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] char_code
  input  logic         in_tlast,    // last_char
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,   // [63:0] addr_high, [127:64] addr_low
  output logic         out_tuser    // malformed
);
  import ipv6tp_pkg::*;

  addr_rec_t push_rec, pop_rec;
  q_ctl_t    q_ctl;
  logic      push, full, pop;

  ipv6tp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (full),
    .q_push    (push),
    .q_rec     (push_rec)
  );

  ipv6tp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .ctl_out  (q_ctl),
    .pop_in   (pop),
    .pop_rec  (pop_rec)
  );

  ipv6tp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_ctl      (q_ctl),
    .q_rec      (pop_rec),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sim/tb_ipv6_text_address_parser_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv6_text_address_parser_unit
// Streams IPv6 address text into the parser one character per request and
// compares every emitted address, both halves and the malformed flag, with a
// cycle-free software parse of the same characters. Directed strings hit the
// corner cases, then random well-formed and faulty addresses run under random
// idling on both sides, one long output hold-off, and a final idle-free burst.
// ----------------------------------------------------------------------------
module tb_ipv6_text_address_parser_unit;
  import ipv6tp_pkg::*;

  localparam int CHARS_RANDOM = 1450;
  localparam int CHARS_TOTAL  = 1850;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 10;

  typedef enum int {
    FAULT_NONE,
    FAULT_EXTRA_GROUPS,
    FAULT_LONG_FIELD,
    FAULT_BAD_CHAR,
    FAULT_NOISE
  } fault_kind_t;

  typedef struct {
    logic [HALF_W-1:0] addr_high;
    logic [HALF_W-1:0] addr_low;
    logic              malformed;
  } parsed_addr_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'h00;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         out_tuser;

  // handshake pacing controls
  bit tx_idle_en  = 1'b1;
  bit rx_idle_en  = 1'b1;
  bit hold_req    = 1'b0;
  bit hold_active = 1'b0;

  // parse state mirrored from the block
  logic [GROUP_W-1:0] grp_words [NUM_GROUPS];
  logic [GROUP_W-1:0] fld_value;
  logic [2:0]         fld_digits;
  logic [3:0]         grp_count;
  logic [3:0]         gap_at;
  logic               bad_seen;

  parsed_addr_t expected_addr_q[$];
  logic [7:0]   text_buf[$];
  string        hex_chars = "0123456789abcdef";

  int chars_sent;
  int addrs_seen;
  int malformed_seen;
  int stall_cycles;
  int mismatches;

  ipv6_text_address_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // address prediction
  // ---------------------------------------------------------------------------
  function automatic void clear_parse_state();
    for (int i = 0; i < NUM_GROUPS; i++) grp_words[i] = '0;
    fld_value  = '0;
    fld_digits = '0;
    grp_count  = '0;
    gap_at     = '0;
    bad_seen   = 1'b0;
  endfunction

  // empty field marks the gap, full field takes the next group slot
  function automatic void close_field();
    if (fld_digits == 3'd0) begin
      gap_at = grp_count;
    end else if (grp_count < GROUPS_FULL) begin
      grp_words[grp_count] = fld_value;
      grp_count++;
    end else begin
      bad_seen = 1'b1;
    end
    fld_value  = '0;
    fld_digits = '0;
  endfunction

  function automatic void track_char(logic [7:0] ch, logic last);
    logic [3:0]         nib;
    logic [GROUP_W-1:0] addr [NUM_GROUPS];
    parsed_addr_t       rec;
    int                 cnt;
    int                 gap;
    int                 start;
    if (ch != CHAR_COLON) begin
      nib = 4'd0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        nib = 4'(ch - CHAR_ZERO);
      end else if (ch >= CHAR_A && ch <= CHAR_F) begin
        nib = 4'(ch - CHAR_A) + TEN;
      end else begin
        bad_seen = 1'b1;
      end
      if (fld_digits >= MAX_DIGITS) begin
        bad_seen = 1'b1;
      end else begin
        fld_digits++;
      end
      fld_value = {fld_value[GROUP_W-5:0], nib};
    end
    if (ch == CHAR_COLON || last) close_field();
    if (last) begin
      // groups after the gap slide to the tail, the hole reads zero
      cnt   = (grp_count > GROUPS_FULL) ? NUM_GROUPS : int'(grp_count);
      gap   = (int'(gap_at) > cnt) ? cnt : int'(gap_at);
      start = NUM_GROUPS - (cnt - gap);
      for (int i = 0; i < NUM_GROUPS; i++) begin
        if (i < gap) begin
          addr[i] = grp_words[i];
        end else if (i < start) begin
          addr[i] = '0;
        end else begin
          addr[i] = grp_words[(gap + i - start) % NUM_GROUPS];
        end
      end
      rec.addr_high = {addr[0], addr[1], addr[2], addr[3]};
      rec.addr_low  = {addr[4], addr[5], addr[6], addr[7]};
      rec.malformed = bad_seen;
      expected_addr_q.push_back(rec);
      clear_parse_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch, input logic last);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
    track_char(ch, last);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_char(text_buf[i], i == text_buf.size() - 1);
    end
  endtask

  task automatic send_string(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  // random address text, well-formed unless a fault is asked for
  task automatic build_address(input fault_kind_t fault);
    int groups;
    int empty_at;
    int empties;
    int long_at;
    int digits;
    text_buf.delete();
    if (fault == FAULT_NOISE) begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom));
      return;
    end
    groups   = (fault == FAULT_EXTRA_GROUPS) ? $urandom_range(9, 10)
             : ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 8);
    empty_at = ($urandom_range(0, 1) == 0 || groups == 0) ? $urandom_range(0, groups) : -1;
    empties  = $urandom_range(1, 3);
    long_at  = (fault == FAULT_LONG_FIELD) ? $urandom_range(0, groups) : -1;
    for (int g = 0; g <= groups; g++) begin
      if (g == empty_at) begin
        repeat (empties) text_buf.push_back(CHAR_COLON);
      end
      if (g < groups || g == long_at) begin
        digits = (g == long_at) ? $urandom_range(5, 7) : $urandom_range(1, 4);
        repeat (digits) text_buf.push_back(hex_chars[$urandom_range(0, 15)]);
        if (g < groups - 1) text_buf.push_back(CHAR_COLON);
      end
    end
    if (text_buf.size() == 0) text_buf.push_back(hex_chars[$urandom_range(0, 15)]);
    if (fault == FAULT_BAD_CHAR) begin
      text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom);
    end
  endtask

  function automatic fault_kind_t pick_fault();
    case ($urandom_range(0, 19))
      0:       return FAULT_EXTRA_GROUPS;
      1:       return FAULT_LONG_FIELD;
      2, 3:    return FAULT_BAD_CHAR;
      4:       return FAULT_NOISE;
      default: return FAULT_NONE;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side: ready pacing and checking
  // ---------------------------------------------------------------------------
  initial begin : ready_gen
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        out_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_active = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    parsed_addr_t want;
    if (rst_n && in_tvalid && !in_tready) stall_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      addrs_seen++;
      if (out_tuser) malformed_seen++;
      if (expected_addr_q.size() == 0) begin
        $error("address emitted with none pending: %h", out_tdata);
        mismatches++;
      end else begin
        want = expected_addr_q.pop_front();
        if (out_tdata[63:0] !== want.addr_high) begin
          $error("addr_high expected %h actual %h", want.addr_high, out_tdata[63:0]);
          mismatches++;
        end
        if (out_tdata[127:64] !== want.addr_low) begin
          $error("addr_low expected %h actual %h", want.addr_low, out_tdata[127:64]);
          mismatches++;
        end
        if (out_tuser !== want.malformed) begin
          $error("malformed expected %b actual %b", want.malformed, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // single digit, bare compression, split address, lone colon, repeated gaps
  task automatic test_short_forms();
    send_string("f");
    send_string("::");
    send_string("1::2");
    send_string(":");
    send_string("a::b::c");
  endtask

  // overlong field, non-hex letter, extreme codes, ninth group
  task automatic test_faults();
    send_string("12345");
    send_string("g");
    text_buf = '{8'h00, 8'hff};
    send_text();
    send_string("1:2:3:4:5:6:7:8:9");
  endtask

  task automatic test_random_text(input int char_goal);
    while (chars_sent < char_goal) begin
      build_address(pick_fault());
      send_text();
    end
  endtask

  // output held off while random well-formed addresses keep arriving
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    // no request on the bus while the hold starts
    in_tvalid <= 1'b0;
    wait (hold_active);
    repeat (12) begin
      build_address(FAULT_NONE);
      send_text();
    end
    tx_idle_en = 1'b1;
  endtask

  task automatic test_no_idle(input int char_goal);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_text(char_goal);
  endtask

  initial begin
    clear_parse_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_short_forms();
    test_faults();
    test_random_text(CHARS_RANDOM);
    test_backpressure();
    test_no_idle(CHARS_TOTAL);
    in_tvalid <= 1'b0;
    wait (expected_addr_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("parsed %0d characters into %0d addresses, %0d of them malformed",
             chars_sent, addrs_seen, malformed_seen);
    $display("input held back for %0d cycles by output stalls", stall_cycles);
    if (mismatches == 0 && expected_addr_q.size() == 0) begin
      $display("[ipv6_text_address_parser_unit] OK");
    end else begin
      $display("[ipv6_text_address_parser_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("[ipv6_text_address_parser_unit] ERROR");
    $finish;
  end

endmodule
